FILE: rtl/telnet_option_negotiator_core_defines.svh
// ----------------------------------------------------------------------------
// Telnet option negotiator assertion macros
// Immediate-cycle and next-cycle implication checks on the core clock.
// ----------------------------------------------------------------------------
`ifndef TELNET_OPTION_NEGOTIATOR_CORE_DEFINES_SVH
`define TELNET_OPTION_NEGOTIATOR_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define TONO_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tono: same-cycle check failed");

// antecedent implies consequent in the next cycle
`define TONO_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tono: next-cycle check failed");

`endif

FILE: rtl/tono_pkg.sv
// ----------------------------------------------------------------------------
// tono_pkg
// Shared codes, widths and transfer types of the telnet option negotiator.
// ----------------------------------------------------------------------------
`default_nettype none

package tono_pkg;

    localparam int CODE_SLOTS       = 8;
    localparam int OPTION_SLOTS_DEF = 8;
    localparam int SLOT_W           = 3;
    localparam int QUEUE_DEPTH      = 2;

    typedef logic [1:0] t_verb;
    localparam t_verb VERB_DO   = 2'd0;
    localparam t_verb VERB_DONT = 2'd1;
    localparam t_verb VERB_WILL = 2'd2;
    localparam t_verb VERB_WONT = 2'd3;

    typedef logic [1:0] t_req;
    localparam t_req REQ_CMD       = 2'd0;
    localparam t_req REQ_SET_LOCAL = 2'd1;
    localparam t_req REQ_SET_PEER  = 2'd2;

    typedef logic [2:0] t_notify;
    localparam t_notify NOTIFY_NONE          = 3'd0;
    localparam t_notify NOTIFY_LOCAL_CONFIRM = 3'd1;
    localparam t_notify NOTIFY_PEER_CONFIRM  = 3'd2;
    localparam t_notify NOTIFY_LOCAL_CHANGE  = 3'd3;
    localparam t_notify NOTIFY_PEER_CHANGE   = 3'd4;

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_OPTION_CODES = 2'd0;
    localparam t_cfg_idx CFG_SLOT_COUNT   = 2'd1;
    localparam t_cfg_idx CFG_ACCEPT_LOCAL = 2'd2;
    localparam t_cfg_idx CFG_ACCEPT_PEER  = 2'd3;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_SEARCH,
        FR_PUSH
    } t_front_state;

    typedef struct packed {
        t_req              req_type;
        t_verb             cmd_verb;
        logic [7:0]        option_code;
        logic              req_value;
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_task;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef struct packed {
        logic       send_valid;
        t_verb      send_verb;
        logic [7:0] send_option;
        t_notify    notify;
        logic       unknown_option;
        logic       agreed;
        logic       agreed_value;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/telnet_option_negotiator_core.sv
// ----------------------------------------------------------------------------
// telnet_option_negotiator_core
// Telnet DO/DONT/WILL/WONT option table with slot search front end.
// ----------------------------------------------------------------------------
// Flow: an input transfer is held while its code is searched against the slot
//   codes until a hit or min(slot_count, slots) slots, then pushed into the queue.
// The front end takes the next input transfer only after it has pushed the last
//   one into the queue, so it stalls during the one-slot-per-cycle code search in
//   the front end and while the queue is full.
// Reset (synchronous, active low) clears config, option table and queue.
`default_nettype none
`include "telnet_option_negotiator_core_defines.svh"

module telnet_option_negotiator_core #(
    parameter int OPTION_SLOTS = tono_pkg::OPTION_SLOTS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire  [1:0]  i_req_type,
    input  wire  [1:0]  i_cmd_verb,
    input  wire  [7:0]  i_option_code,
    input  wire         i_req_value,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output logic        o_send_valid,
    output logic [1:0]  o_send_verb,
    output logic [7:0]  o_send_option,
    output logic [2:0]  o_notify,
    output logic        o_unknown_option,
    output logic        o_agreed,
    output logic        o_agreed_value,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [63:0] i_cfg_data
);

    logic [63:0] r_option_codes;
    logic [3:0]  r_slot_count;
    logic [7:0]  r_accept_local;
    logic [7:0]  r_accept_peer;

    tono_pkg::t_queue_status w_q_status;
    tono_pkg::t_task         w_front_task;
    tono_pkg::t_task         w_back_task;
    tono_pkg::t_result       w_result;
    logic                    w_push;
    logic                    w_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_option_codes <= '0;
            r_slot_count   <= '0;
            r_accept_local <= '0;
            r_accept_peer  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tono_pkg::CFG_OPTION_CODES: r_option_codes <= i_cfg_data;
                tono_pkg::CFG_SLOT_COUNT:   r_slot_count   <= i_cfg_data[3:0];
                tono_pkg::CFG_ACCEPT_LOCAL: r_accept_local <= i_cfg_data[7:0];
                tono_pkg::CFG_ACCEPT_PEER:  r_accept_peer  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    tono_front #(
        .OPTION_SLOTS (OPTION_SLOTS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_cmd_verb     (i_cmd_verb),
        .i_option_code  (i_option_code),
        .i_req_value    (i_req_value),
        .i_option_codes (r_option_codes),
        .i_slot_count   (r_slot_count),
        .i_q_status     (w_q_status),
        .o_push         (w_push),
        .o_task         (w_front_task)
    );

    tono_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_front_task),
        .i_pop    (w_pop),
        .o_data   (w_back_task),
        .o_status (w_q_status)
    );

    tono_back #(
        .OPTION_SLOTS (OPTION_SLOTS)
    ) u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_q_status          (w_q_status),
        .i_task              (w_back_task),
        .o_pop               (w_pop),
        .i_accept_local_mask (r_accept_local),
        .i_accept_peer_mask  (r_accept_peer),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_result            (w_result)
    );

    assign o_send_valid     = w_result.send_valid;
    assign o_send_verb      = w_result.send_verb;
    assign o_send_option    = w_result.send_option;
    assign o_notify         = w_result.notify;
    assign o_unknown_option = w_result.unknown_option;
    assign o_agreed         = w_result.agreed;
    assign o_agreed_value   = w_result.agreed_value;

    `TONO_ASSERT_IMP(a_idle_send_zero, i_clk, i_rst_n, o_out_valid && !o_send_valid, (o_send_verb == tono_pkg::VERB_DO) && (o_send_option == 8'd0))
    `TONO_ASSERT_IMP(a_unknown_quiet, i_clk, i_rst_n, o_out_valid && o_unknown_option, !o_agreed && (o_notify == tono_pkg::NOTIFY_NONE))
    `TONO_ASSERT_IMP(a_value_needs_agree, i_clk, i_rst_n, o_out_valid && o_agreed_value, o_agreed)
    `TONO_ASSERT_NXT(a_busy_after_transfer, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

endmodule

`default_nettype wire

FILE: rtl/tono_front.sv
// ----------------------------------------------------------------------------
// tono_front
// Accepts items and searches the slot codes one slot per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tono_front #(
    parameter int OPTION_SLOTS = tono_pkg::OPTION_SLOTS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire  [1:0]             i_req_type,
    input  wire  [1:0]             i_cmd_verb,
    input  wire  [7:0]             i_option_code,
    input  wire                    i_req_value,
    input  wire  [63:0]            i_option_codes,
    input  wire  [3:0]             i_slot_count,
    input  tono_pkg::t_queue_status i_q_status,
    output logic                   o_push,
    output tono_pkg::t_task        o_task
);

    localparam int NSLOT = (OPTION_SLOTS < tono_pkg::CODE_SLOTS) ?
                           OPTION_SLOTS : tono_pkg::CODE_SLOTS;
    localparam int CW    = $clog2(NSLOT + 1);
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    tono_pkg::t_front_state r_state, n_state;
    tono_pkg::t_task        r_task;
    logic [CW-1:0]          r_cnt;

    logic [7:0]    w_codes [NSLOT];
    logic [CW-1:0] w_limit;
    logic          w_at_end;
    logic          w_match;
    logic          w_accept;

    genvar g;
    generate
        for (g = 0; g < NSLOT; g++) begin : g_codes
            assign w_codes[g] = i_option_codes[8*g +: 8];
        end
    endgenerate

    assign w_limit  = (i_slot_count > 4'(NSLOT)) ? CW'(NSLOT) : CW'(i_slot_count);
    assign w_at_end = (r_cnt == w_limit);
    assign w_match  = (w_codes[r_cnt[IW-1:0]] == r_task.option_code);
    assign w_accept = i_in_valid && !o_in_stall;
    assign o_task   = r_task;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tono_pkg::FR_IDLE: begin
                if (i_in_valid) n_state = tono_pkg::FR_SEARCH;
            end
            tono_pkg::FR_SEARCH: begin
                if (w_at_end || w_match) n_state = tono_pkg::FR_PUSH;
            end
            tono_pkg::FR_PUSH: begin
                if (!i_q_status.full) n_state = tono_pkg::FR_IDLE;
            end
            default: n_state = tono_pkg::FR_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        o_push     = 1'b0;
        unique case (r_state)
            tono_pkg::FR_IDLE:   o_in_stall = 1'b0;
            tono_pkg::FR_SEARCH: o_in_stall = 1'b1;
            tono_pkg::FR_PUSH:   o_push     = !i_q_status.full;
            default:             o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tono_pkg::FR_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_cnt <= '0;
            end else if (r_state == tono_pkg::FR_SEARCH && !w_at_end && !w_match) begin
                r_cnt <= r_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_task.req_type    <= i_req_type;
            r_task.cmd_verb    <= i_cmd_verb;
            r_task.option_code <= i_option_code;
            r_task.req_value   <= i_req_value;
            r_task.hit         <= 1'b0;
            r_task.slot        <= '0;
        end else if (r_state == tono_pkg::FR_SEARCH && !w_at_end && w_match) begin
            r_task.hit  <= 1'b1;
            r_task.slot <= tono_pkg::SLOT_W'(r_cnt);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tono_fifo.sv
// ----------------------------------------------------------------------------
// tono_fifo
// Short queue of classified items between the search and the table update.
// ----------------------------------------------------------------------------
`default_nettype none

module tono_fifo (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  tono_pkg::t_task         i_data,
    input  wire                     i_pop,
    output tono_pkg::t_task         o_data,
    output tono_pkg::t_queue_status o_status
);

    localparam int DEPTH = tono_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    tono_pkg::t_task r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [NW-1:0]   r_count;

    logic w_push;
    logic w_pop;

    assign o_status.full  = (r_count == NW'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + NW'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - NW'(1);
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/tono_back.sv
// ----------------------------------------------------------------------------
// tono_back
// Applies one classified item to the option table and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module tono_back #(
    parameter int OPTION_SLOTS = tono_pkg::OPTION_SLOTS_DEF
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  tono_pkg::t_queue_status i_q_status,
    input  tono_pkg::t_task         i_task,
    output logic                    o_pop,
    input  wire  [7:0]              i_accept_local_mask,
    input  wire  [7:0]              i_accept_peer_mask,
    output logic                    o_out_valid,
    input  wire                     i_out_stall,
    output tono_pkg::t_result       o_result
);

    localparam int NSLOT = (OPTION_SLOTS < tono_pkg::CODE_SLOTS) ?
                           OPTION_SLOTS : tono_pkg::CODE_SLOTS;
    localparam int IW    = (NSLOT > 1) ? $clog2(NSLOT) : 1;

    logic [NSLOT-1:0]  r_local_en,  n_local_en;
    logic [NSLOT-1:0]  r_local_wt,  n_local_wt;
    logic [NSLOT-1:0]  r_peer_en,   n_peer_en;
    logic [NSLOT-1:0]  r_peer_wt,   n_peer_wt;
    logic              r_out_valid;
    tono_pkg::t_result r_result,    n_result;

    logic          w_load;
    logic [IW-1:0] w_s;

    assign w_load      = !i_q_status.empty && (!r_out_valid || !i_out_stall);
    assign o_pop       = w_load;
    assign w_s         = i_task.slot[IW-1:0];
    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

    always_comb begin
        logic v;
        logic acc_l;
        logic acc_p;
        n_local_en = r_local_en;
        n_local_wt = r_local_wt;
        n_peer_en  = r_peer_en;
        n_peer_wt  = r_peer_wt;
        n_result   = '0;
        v          = 1'b0;
        acc_l      = i_accept_local_mask[i_task.slot];
        acc_p      = i_accept_peer_mask[i_task.slot];
        if (!i_task.hit) begin
            n_result.unknown_option = 1'b1;
            if (i_task.req_type == tono_pkg::REQ_CMD) begin
                if (i_task.cmd_verb == tono_pkg::VERB_DO) begin
                    n_result.send_valid = 1'b1;
                    n_result.send_verb  = tono_pkg::VERB_WONT;
                end else if (i_task.cmd_verb == tono_pkg::VERB_WILL) begin
                    n_result.send_valid = 1'b1;
                    n_result.send_verb  = tono_pkg::VERB_DONT;
                end
            end
        end else begin
            case (i_task.req_type)
                tono_pkg::REQ_CMD: begin
                    case (i_task.cmd_verb) inside
                        tono_pkg::VERB_DO, tono_pkg::VERB_DONT: begin
                            v = (i_task.cmd_verb == tono_pkg::VERB_DO);
                            if (r_local_wt[w_s]) begin
                                n_local_en[w_s] = v;
                                n_local_wt[w_s] = 1'b0;
                                n_result.notify = tono_pkg::NOTIFY_LOCAL_CONFIRM;
                            end else if (r_local_en[w_s] != v && acc_l) begin
                                n_local_en[w_s]     = v;
                                n_result.send_valid = 1'b1;
                                n_result.send_verb  = v ? tono_pkg::VERB_WILL :
                                                          tono_pkg::VERB_WONT;
                                n_result.notify     = tono_pkg::NOTIFY_LOCAL_CHANGE;
                            end
                        end
                        default: begin
                            v = (i_task.cmd_verb == tono_pkg::VERB_WILL);
                            if (r_peer_wt[w_s]) begin
                                n_peer_en[w_s]  = v;
                                n_peer_wt[w_s]  = 1'b0;
                                n_result.notify = tono_pkg::NOTIFY_PEER_CONFIRM;
                            end else if (r_peer_en[w_s] != v && acc_p) begin
                                n_peer_en[w_s]      = v;
                                n_result.send_valid = 1'b1;
                                n_result.send_verb  = v ? tono_pkg::VERB_DO :
                                                          tono_pkg::VERB_DONT;
                                n_result.notify     = tono_pkg::NOTIFY_PEER_CHANGE;
                            end
                        end
                    endcase
                end
                tono_pkg::REQ_SET_LOCAL: begin
                    if (r_local_en[w_s] != i_task.req_value) begin
                        n_local_en[w_s]     = i_task.req_value;
                        n_local_wt[w_s]     = 1'b1;
                        n_result.send_valid = 1'b1;
                        n_result.send_verb  = i_task.req_value ? tono_pkg::VERB_WILL :
                                                                 tono_pkg::VERB_WONT;
                    end
                end
                tono_pkg::REQ_SET_PEER: begin
                    if (r_peer_en[w_s] != i_task.req_value) begin
                        n_peer_en[w_s]      = i_task.req_value;
                        n_peer_wt[w_s]      = 1'b1;
                        n_result.send_valid = 1'b1;
                        n_result.send_verb  = i_task.req_value ? tono_pkg::VERB_DO :
                                                                 tono_pkg::VERB_DONT;
                    end
                end
                default: ;
            endcase
            if (!n_local_wt[w_s] && !n_peer_wt[w_s] && (n_local_en[w_s] == n_peer_en[w_s])) begin
                n_result.agreed       = 1'b1;
                n_result.agreed_value = n_local_en[w_s];
            end
        end
        n_result.send_option = n_result.send_valid ? i_task.option_code : 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_en  <= '0;
            r_local_wt  <= '0;
            r_peer_en   <= '0;
            r_peer_wt   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_local_en  <= n_local_en;
                r_local_wt  <= n_local_wt;
                r_peer_en   <= n_peer_en;
                r_peer_wt   <= n_peer_wt;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) r_result <= n_result;
    end

endmodule

`default_nettype wire
